// ===== hdl/turtle_vector_command_engine_macros.svh =====
// Assertion macros of the turtle vector command engine checker.
`ifndef TURTLE_VECTOR_COMMAND_ENGINE_MACROS_SVH
`define TURTLE_VECTOR_COMMAND_ENGINE_MACROS_SVH

// Clocked assertion, off while reset is high.
`define TVCE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define TVCE_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/tvce_pkg.sv =====
// Shared types, constants and table functions of the turtle vector command engine.
`default_nettype none

package tvce_pkg;

   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 240;
   localparam int QUEUE_DEPTH_DEF   = 4;
   localparam int FULL_TURN         = 360;

   localparam int COORD_W    = 24;
   localparam int PIX_W      = 16;
   localparam int COLOR_W    = 8;
   localparam int FUNC_W     = 3;
   localparam int HEAD_W     = 17;
   localparam int SINE_W     = 16;
   localparam int HV_W       = 26;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;

   localparam logic [FUNC_W-1:0] FUNC_FORWARD  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_RIGHT    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LEFT     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SET_HEAD = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_GOTO     = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_TELEPORT = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_PEN_DOWN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEN_COLOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP      = 2'd2;

   typedef enum logic [2:0] {
      KIND_FWD   = 3'd0,
      KIND_RIGHT = 3'd1,
      KIND_LEFT  = 3'd2,
      KIND_SET   = 3'd3,
      KIND_GOTO  = 3'd4,
      KIND_TELE  = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [COORD_W-1:0]  amount;
      logic signed [COORD_W-1:0]  x_target;
      logic signed [COORD_W-1:0]  y_target;
   } cmd_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   // Quarter wave of sine in Q1.14, whole degrees 0 to 90.
   localparam logic signed [SINE_W-1:0] QUARTER_SINE [0:90] = '{
      16'sd0, 16'sd286, 16'sd572, 16'sd857, 16'sd1143, 16'sd1428, 16'sd1713,
      16'sd1997, 16'sd2280, 16'sd2563, 16'sd2845, 16'sd3126, 16'sd3406,
      16'sd3686, 16'sd3964, 16'sd4240, 16'sd4516, 16'sd4790, 16'sd5063,
      16'sd5334, 16'sd5604, 16'sd5872, 16'sd6138, 16'sd6402, 16'sd6664,
      16'sd6924, 16'sd7182, 16'sd7438, 16'sd7692, 16'sd7943, 16'sd8192,
      16'sd8438, 16'sd8682, 16'sd8923, 16'sd9162, 16'sd9397, 16'sd9630,
      16'sd9860, 16'sd10087, 16'sd10311, 16'sd10531, 16'sd10749, 16'sd10963,
      16'sd11174, 16'sd11381, 16'sd11585, 16'sd11786, 16'sd11982, 16'sd12176,
      16'sd12365, 16'sd12551, 16'sd12733, 16'sd12911, 16'sd13085, 16'sd13255,
      16'sd13421, 16'sd13583, 16'sd13741, 16'sd13894, 16'sd14044, 16'sd14189,
      16'sd14330, 16'sd14466, 16'sd14598, 16'sd14726, 16'sd14849, 16'sd14968,
      16'sd15082, 16'sd15191, 16'sd15296, 16'sd15396, 16'sd15491, 16'sd15582,
      16'sd15668, 16'sd15749, 16'sd15826, 16'sd15897, 16'sd15964, 16'sd16026,
      16'sd16083, 16'sd16135, 16'sd16182, 16'sd16225, 16'sd16262, 16'sd16294,
      16'sd16322, 16'sd16344, 16'sd16362, 16'sd16374, 16'sd16382, 16'sd16384
   };

   // Sine of a whole degree below a full turn, by quarter-wave symmetry.
   function automatic logic signed [SINE_W-1:0] sine_lookup(input logic [8:0] deg);
      logic [8:0]               half;
      logic [8:0]               quad;
      logic signed [SINE_W-1:0] mag;
      half = (deg < 9'd180) ? deg : deg - 9'd180;
      quad = (half <= 9'd90) ? half : 9'd180 - half;
      mag  = QUARTER_SINE[quad[6:0]];
      return (deg >= 9'd180) ? -mag : mag;
   endfunction

   // Degree whose sine is the cosine of deg.
   function automatic logic [8:0] cos_index(input logic [8:0] deg);
      return (deg >= 9'd270) ? deg - 9'd270 : deg + 9'd90;
   endfunction

   // Q16.8 to whole pixels, truncated toward zero, low 16 bits.
   function automatic logic [PIX_W-1:0] to_pixel(input logic signed [COORD_W-1:0] v);
      logic signed [COORD_W:0] biased;
      biased = 25'(v) + (v[COORD_W-1] ? 25'sd255 : 25'sd0);
      return biased[COORD_W-1:8];
   endfunction

   // Clamp to the signed Q16.8 range.
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [27:0] v);
      if (v > 28'sd8388607) begin
         return 24'sh7FFFFF;
      end
      if (v < -28'sd8388608) begin
         return 24'sh800000;
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/tvce_front.sv =====
// Command front end: takes request words and classifies the function code.
`default_nettype none

module tvce_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tvce_pkg::REQ_DATA_W-1:0]  req_tdata,  // amount, x_target, y_target
   input  logic [tvce_pkg::FUNC_W-1:0]      req_tuser,  // func
   input  logic                             push_ready,
   output logic                             push_valid,
   output tvce_pkg::cmd_type                push_item
);
   import tvce_pkg::*;

   logic known;

   always_comb begin
      known          = 1'b1;
      push_item.kind = KIND_FWD;
      case (req_tuser)
         FUNC_FORWARD:  push_item.kind = KIND_FWD;
         FUNC_RIGHT:    push_item.kind = KIND_RIGHT;
         FUNC_LEFT:     push_item.kind = KIND_LEFT;
         FUNC_SET_HEAD: push_item.kind = KIND_SET;
         FUNC_GOTO:     push_item.kind = KIND_GOTO;
         FUNC_TELEPORT: push_item.kind = KIND_TELE;
         default:       known = 1'b0;
      endcase
      push_item.amount   = $signed(req_tdata[23:0]);
      push_item.x_target = $signed(req_tdata[47:24]);
      push_item.y_target = $signed(req_tdata[71:48]);
   end

   // Unused function codes are taken and dropped here.
   assign req_tready = push_ready;
   assign push_valid = req_tvalid && known;

endmodule

`default_nettype wire

// ===== hdl/tvce_queue.sv =====
// Short command queue between the front end and the execution back end.
`default_nettype none

module tvce_queue #(
   parameter int DEPTH = tvce_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tvce_pkg::cmd_type  push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tvce_pkg::cmd_type  pop_item
);
   import tvce_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tvce_mod_unit.sv =====
// Floor modulo of a Q.8 value by a constant times 256, by reciprocal multiply.
`default_nettype none

module tvce_mod_unit #(
   parameter int MODULUS = tvce_pkg::SCREEN_WIDTH_DEF,
   parameter int IN_W    = tvce_pkg::COORD_W
) (
   input  logic                          clock,
   input  logic signed [IN_W-1:0]        in_value,
   output logic [$clog2(MODULUS)+7:0]    out_value
);
   localparam int INT_W   = IN_W - 8;
   localparam int U_W     = IN_W - 7;
   localparam int OFFSET  = MODULUS * ((2 ** (INT_W - 1) + MODULUS - 1) / MODULUS);
   localparam int SHIFT   = 28;
   localparam int RECIP   = (2 ** SHIFT) / MODULUS;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = U_W + RECIP_W;
   localparam int REM_W   = $clog2(MODULUS);

   logic [U_W-1:0]    u_in;
   logic [U_W-1:0]    u_ff;
   logic [U_W-1:0]    q_ff;
   logic [7:0]        frac_ff;
   logic [PROD_W-1:0] prod;
   logic [U_W-1:0]    r_raw;
   logic [U_W-1:0]    r_fix;

   // Bias the integer part by a multiple of the modulus so it is never negative.
   assign u_in = U_W'($signed(in_value[IN_W-1:8])) + U_W'(OFFSET);
   assign prod = PROD_W'(u_in) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      q_ff    <= U_W'(prod >> SHIFT);
      frac_ff <= in_value[7:0];
   end

   // The quotient estimate is low by at most one: one correction step.
   assign r_raw     = u_ff - U_W'(q_ff * U_W'(MODULUS));
   assign r_fix     = (r_raw >= U_W'(MODULUS)) ? r_raw - U_W'(MODULUS) : r_raw;
   assign out_value = {r_fix[REM_W-1:0], frac_ff};

endmodule

`default_nettype wire

// ===== hdl/tvce_back.sv =====
// Execution back end: heading, position, wrapping and segment output.
`default_nettype none

module tvce_back #(
   parameter int SCREEN_WIDTH  = tvce_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tvce_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tvce_pkg::csr_write_type          csr,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  tvce_pkg::cmd_type                pop_item,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tvce_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);
   import tvce_pkg::*;

   localparam int WX_W = $clog2(SCREEN_WIDTH) + 8;
   localparam int WY_W = $clog2(SCREEN_HEIGHT) + 8;
   localparam logic signed [COORD_W-1:0] SPAN_X = COORD_W'(SCREEN_WIDTH * 256);
   localparam logic signed [COORD_W-1:0] SPAN_Y = COORD_W'(SCREEN_HEIGHT * 256);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL  = 8'b0000_0010,
      ST_SUM  = 8'b0000_0100,
      ST_HMOD = 8'b0000_1000,
      ST_HWR  = 8'b0001_0000,
      ST_MOVE = 8'b0010_0000,
      ST_SEG1 = 8'b0100_0000,
      ST_SEG2 = 8'b1000_0000
   } state_type;

   state_type                   state_ff;
   state_type                   state_in;
   logic                        pen_down_ff;
   logic [COLOR_W-1:0]          pen_color_ff;
   logic                        wrap_ff;
   logic signed [COORD_W-1:0]   pos_x_ff;
   logic signed [COORD_W-1:0]   pos_y_ff;
   logic [HEAD_W-1:0]           heading_ff;
   logic signed [COORD_W-1:0]   amount_ff;
   logic signed [SINE_W-1:0]    sin_ff;
   logic signed [SINE_W-1:0]    cos_ff;
   logic signed [39:0]          prod_x_ff;
   logic signed [39:0]          prod_y_ff;
   logic signed [HV_W-1:0]      hv_ff;
   logic signed [COORD_W-1:0]   nx_ff;
   logic signed [COORD_W-1:0]   ny_ff;
   logic                        draw_ff;
   logic signed [COORD_W-1:0]   ox_ff;
   logic signed [COORD_W-1:0]   oy_ff;
   logic [WX_W-1:0]             wx_ff;
   logic [WY_W-1:0]             wy_ff;
   logic [WX_W-1:0]             wox_ff;
   logic [WY_W-1:0]             woy_ff;
   logic                        rsp_valid_ff;
   logic [RSP_DATA_W-1:0]       rsp_data_ff;
   logic                        rsp_last_ff;

   logic                        slot_free;
   logic [8:0]                  head_deg;
   logic signed [HV_W-1:0]      head_ext;
   logic signed [HV_W-1:0]      amt_ext;
   logic signed [HV_W-1:0]      hv_next;
   logic [HEAD_W-1:0]           head_wrap;
   logic [WX_W-1:0]             wnx;
   logic [WY_W-1:0]             wny;
   logic [WX_W-1:0]             wpx;
   logic [WY_W-1:0]             wpy;
   logic signed [41:0]          round_x;
   logic signed [41:0]          round_y;
   logic signed [27:0]          sum_x;
   logic signed [27:0]          sum_y;
   logic signed [COORD_W-1:0]   wx_s;
   logic signed [COORD_W-1:0]   wy_s;
   logic signed [COORD_W-1:0]   wox_s;
   logic signed [COORD_W-1:0]   woy_s;
   logic signed [COORD_W-1:0]   sx2;
   logic signed [COORD_W-1:0]   sy2;

   tvce_mod_unit #(.MODULUS(FULL_TURN), .IN_W(HV_W)) u_mod_head (
      .clock(clock), .in_value(hv_ff), .out_value(head_wrap)
   );
   tvce_mod_unit #(.MODULUS(SCREEN_WIDTH), .IN_W(COORD_W)) u_mod_nx (
      .clock(clock), .in_value(nx_ff), .out_value(wnx)
   );
   tvce_mod_unit #(.MODULUS(SCREEN_HEIGHT), .IN_W(COORD_W)) u_mod_ny (
      .clock(clock), .in_value(ny_ff), .out_value(wny)
   );
   tvce_mod_unit #(.MODULUS(SCREEN_WIDTH), .IN_W(COORD_W)) u_mod_px (
      .clock(clock), .in_value(pos_x_ff), .out_value(wpx)
   );
   tvce_mod_unit #(.MODULUS(SCREEN_HEIGHT), .IN_W(COORD_W)) u_mod_py (
      .clock(clock), .in_value(pos_y_ff), .out_value(wpy)
   );

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign pop_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign head_deg = heading_ff[HEAD_W-1:8];
   assign head_ext = HV_W'(heading_ff);
   assign amt_ext  = HV_W'(pop_item.amount);

   always_comb begin
      case (pop_item.kind)
         KIND_RIGHT: hv_next = head_ext - amt_ext;
         KIND_LEFT:  hv_next = head_ext + amt_ext;
         default:    hv_next = amt_ext;
      endcase
   end

   // Round the Q.22 products to Q16.8 by adding one half and taking the floor, then add and clamp.
   assign round_x = 42'(prod_x_ff) + 42'sd8192;
   assign round_y = 42'sd8192 - 42'(prod_y_ff);
   assign sum_x   = 28'(pos_x_ff) + $signed(round_x[41:14]);
   assign sum_y   = 28'(pos_y_ff) + $signed(round_y[41:14]);

   // Wrapped segment start, per axis: wrapped old position moved one screen, or old if no wrap.
   assign wx_s  = COORD_W'(wx_ff);
   assign wy_s  = COORD_W'(wy_ff);
   assign wox_s = COORD_W'(wox_ff);
   assign woy_s = COORD_W'(woy_ff);

   always_comb begin
      if (wx_s < nx_ff) begin
         sx2 = wox_s - SPAN_X;
      end else if (wx_s > nx_ff) begin
         sx2 = wox_s + SPAN_X;
      end else begin
         sx2 = ox_ff;
      end
      if (wy_s < ny_ff) begin
         sy2 = woy_s - SPAN_Y;
      end else if (wy_s > ny_ff) begin
         sy2 = woy_s + SPAN_Y;
      end else begin
         sy2 = oy_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               case (pop_item.kind)
                  KIND_FWD:                       state_in = ST_MUL;
                  KIND_RIGHT, KIND_LEFT, KIND_SET: state_in = ST_HMOD;
                  KIND_GOTO, KIND_TELE:           state_in = ST_MOVE;
                  default:                        state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_MOVE;
         ST_HMOD: state_in = ST_HWR;
         ST_HWR:  state_in = ST_IDLE;
         ST_MOVE: state_in = ST_SEG1;
         ST_SEG1: begin
            if (!draw_ff || slot_free) begin
               state_in = (draw_ff && wrap_ff) ? ST_SEG2 : ST_IDLE;
            end
         end
         ST_SEG2: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_down_ff  <= 1'b0;
         pen_color_ff <= '0;
         wrap_ff      <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr.valid) begin
            case (csr.index)
               CSR_PEN_DOWN:  pen_down_ff  <= csr.data[0];
               CSR_PEN_COLOR: pen_color_ff <= csr.data;
               CSR_WRAP:      wrap_ff      <= csr.data[0];
               default:       ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_HWR: heading_ff <= head_wrap;
            ST_SEG1: begin
               if (!draw_ff || slot_free) begin
                  if (draw_ff) begin
                     rsp_valid_ff <= 1'b1;
                  end
                  if (wrap_ff) begin
                     pos_x_ff <= COORD_W'(wnx);
                     pos_y_ff <= COORD_W'(wny);
                  end else begin
                     pos_x_ff <= nx_ff;
                     pos_y_ff <= ny_ff;
                  end
               end
            end
            ST_SEG2: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               amount_ff <= pop_item.amount;
               sin_ff    <= sine_lookup(head_deg);
               cos_ff    <= sine_lookup(cos_index(head_deg));
               hv_ff     <= hv_next;
               nx_ff     <= pop_item.x_target;
               ny_ff     <= pop_item.y_target;
               draw_ff   <= pen_down_ff &&
                            (pop_item.kind == KIND_FWD || pop_item.kind == KIND_GOTO);
            end
         end
         ST_MUL: begin
            prod_x_ff <= 40'(amount_ff) * 40'(sin_ff);
            prod_y_ff <= 40'(amount_ff) * 40'(cos_ff);
         end
         ST_SUM: begin
            nx_ff <= sat_coord(sum_x);
            ny_ff <= sat_coord(sum_y);
         end
         ST_SEG1: begin
            // Hold the old position and all wrapped values for the second word.
            ox_ff  <= pos_x_ff;
            oy_ff  <= pos_y_ff;
            wx_ff  <= wnx;
            wy_ff  <= wny;
            wox_ff <= wpx;
            woy_ff <= wpy;
            if (draw_ff && slot_free) begin
               rsp_data_ff <= {pen_color_ff, to_pixel(ny_ff), to_pixel(nx_ff),
                               to_pixel(pos_y_ff), to_pixel(pos_x_ff)};
               rsp_last_ff <= !wrap_ff;
            end
         end
         ST_SEG2: begin
            if (slot_free) begin
               rsp_data_ff <= {pen_color_ff, to_pixel(wy_s), to_pixel(wx_s),
                               to_pixel(sy2), to_pixel(sx2)};
               rsp_last_ff <= 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/turtle_vector_command_engine.sv =====
// Flow: a command waits in the queue until the back end is idle; go to and teleport
//   pass through MOVE and SEG1, forward through MUL, SUM, MOVE and SEG1, turns and set
//   heading through HMOD and HWR. The back end takes a new command only from idle, and
//   SEG1 and SEG2 wait on the response; the queue takes a word per cycle while it has room.
// Reset: synchronous, active high; clears position, heading, CSR settings and the queue.
`default_nettype none

module turtle_vector_command_engine #(
   parameter int SCREEN_WIDTH  = tvce_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tvce_pkg::SCREEN_HEIGHT_DEF,
   parameter int QUEUE_DEPTH   = tvce_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tvce_pkg::REQ_DATA_W-1:0]  req_tdata,  // amount, x_target, y_target
   input  logic [tvce_pkg::FUNC_W-1:0]      req_tuser,  // func
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tvce_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // start_x, start_y, end_x, end_y,
                                                        // line_color
   output logic                             rsp_tlast,  // last_segment
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tvce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tvce_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tvce_pkg::*;

   logic          push_valid;
   logic          push_ready;
   cmd_type       push_item;
   logic          pop_valid;
   logic          pop_ready;
   cmd_type       pop_item;
   csr_write_type csr;

   assign csr_ready  = 1'b1;
   assign csr.valid  = csr_valid;
   assign csr.index  = csr_index;
   assign csr.data   = csr_data;

   tvce_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   tvce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   tvce_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hdl/tvce_checker.sv =====
// Port-level checks of the turtle vector command engine, bound to the top level.
`default_nettype none
`include "turtle_vector_command_engine_macros.svh"

module tvce_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [tvce_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tlast
);
   import tvce_pkg::*;

   logic second_due_ff;

   // Track a taken first word of a wrapped pair.
   always_ff @(posedge clock) begin
      if (reset) begin
         second_due_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         second_due_ff <= !rsp_tlast;
      end
   end

   `TVCE_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp word changed while stalled")
   `TVCE_ASSERT(a_pair_order, rsp_tvalid && second_due_ff |-> rsp_tlast, "word after a first segment is not the last")
   `TVCE_ASSERT_RST(a_reset_quiet, reset |=> !rsp_tvalid, "rsp valid right after reset")

endmodule

bind turtle_vector_command_engine tvce_checker u_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench of the turtle vector command engine: stream stimulus, segment checks.
`timescale 1ns / 1ps

module tb;
   import tvce_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
   localparam longint SCR_W = 320 * 256;
   localparam longint SCR_H = 240 * 256;
   localparam longint TURN_Q8 = FULL_TURN * 256;
   localparam longint Q_MAX = 8388607;
   localparam longint Q_MIN = -8388608;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE = 40;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [COORD_W-1:0] amount;
      logic [COORD_W-1:0] xt;
      logic [COORD_W-1:0] yt;
   } req_item_type;

   typedef struct {
      logic [PIX_W-1:0]   sx, sy, ex, ey;
      logic [COLOR_W-1:0] color;
      logic               last;
   } seg_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   turtle_vector_command_engine dut (.*);

   req_item_type pending_cmds[$];
   seg_type segs_due[$];
   longint pen_x, pen_y, head_q8;
   bit draw_en, wrap_on;
   logic [COLOR_W-1:0] ink;
   logic signed [SINE_W-1:0] sine_deg[FULL_TURN];
   int fails = 0, cycles = 0, cmds_sent = 0, segs_seen = 0;
   int send_gap = 0, recv_stall = 0;
   bit calm = 0;

   initial forever #5 clock = ~clock;

   function automatic longint sx24(logic [COORD_W-1:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint wrap_mod(longint v, longint m);
      longint r;
      r = v % m;
      return (r < 0) ? r + m : r;
   endfunction

   function automatic longint clamp_q(longint v);
      return (v > Q_MAX) ? Q_MAX : (v < Q_MIN) ? Q_MIN : v;
   endfunction

   function automatic logic [PIX_W-1:0] pix(longint v);
      longint p;
      p = (v >= 0) ? (v >>> 8) : -((-v) >>> 8);
      return p[PIX_W-1:0];
   endfunction

   function automatic void add_seg(longint ax, longint ay, longint bx, longint by, bit last);
      seg_type s;
      s.sx = pix(ax); s.sy = pix(ay); s.ex = pix(bx); s.ey = pix(by);
      s.color = ink; s.last = last;
      segs_due.push_back(s);
   endfunction

   function automatic void move_pen(longint nx, longint ny, bit draw);
      longint ox, oy;
      ox = pen_x; oy = pen_y;
      pen_x = nx; pen_y = ny;
      if (draw) add_seg(ox, oy, nx, ny, !wrap_on);
      if (wrap_on) begin
         pen_x = wrap_mod(nx, SCR_W);
         pen_y = wrap_mod(ny, SCR_H);
         if (draw) begin
            if (pen_x < nx) ox = wrap_mod(ox, SCR_W) - SCR_W;
            else if (pen_x > nx) ox = wrap_mod(ox, SCR_W) + SCR_W;
            if (pen_y < ny) oy = wrap_mod(oy, SCR_H) - SCR_H;
            else if (pen_y > ny) oy = wrap_mod(oy, SCR_H) + SCR_H;
            add_seg(ox, oy, pen_x, pen_y, 1);
         end
      end
   endfunction

   function automatic void predict_cmd(req_item_type c);
      longint amt, sn, cs, dx, dy;
      int deg;
      amt = sx24(c.amount);
      case (c.func)
         FUNC_FORWARD: begin
            deg = int'(head_q8 >>> 8);
            if (deg >= FULL_TURN) deg = 0;
            sn = sine_deg[deg];
            cs = sine_deg[(deg + 90) % FULL_TURN];
            dx = (amt * sn + 8192) >>> 14;
            dy = (-(amt * cs) + 8192) >>> 14;
            move_pen(clamp_q(pen_x + dx), clamp_q(pen_y + dy), draw_en);
         end
         FUNC_RIGHT:    head_q8 = wrap_mod(head_q8 - amt, TURN_Q8);
         FUNC_LEFT:     head_q8 = wrap_mod(head_q8 + amt, TURN_Q8);
         FUNC_SET_HEAD: head_q8 = wrap_mod(amt, TURN_Q8);
         FUNC_GOTO:     move_pen(sx24(c.xt), sx24(c.yt), draw_en);
         FUNC_TELEPORT: move_pen(sx24(c.xt), sx24(c.yt), 0);
         default: ;
      endcase
   endfunction

   function automatic void queue_cmd(logic [FUNC_W-1:0] f, longint a, longint x, longint y);
      req_item_type c;
      c.func = f; c.amount = a[23:0]; c.xt = x[23:0]; c.yt = y[23:0];
      pending_cmds.push_back(c);
   endfunction

   function automatic longint pick_amount(bit is_turn);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return is_turn ? longint'($urandom_range(0, 2 * 720 * 256)) - 720 * 256
                                 : longint'($urandom_range(0, 2 * 96 * 256)) - 96 * 256;
      if (r < 88) return sx24(COORD_W'($urandom()));
      if (r < 94) return Q_MAX;
      return Q_MIN;
   endfunction

   function automatic longint pick_coord(longint span);
      if ($urandom_range(0, 9) < 7)
         return longint'($urandom_range(0, 3 * span)) - span;
      return sx24(COORD_W'($urandom()));
   endfunction

   function automatic void queue_random();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) queue_cmd(FUNC_FORWARD, pick_amount(0), 0, 0);
      else if (r < 45) queue_cmd(FUNC_RIGHT, pick_amount(1), 0, 0);
      else if (r < 55) queue_cmd(FUNC_LEFT, pick_amount(1), 0, 0);
      else if (r < 63) queue_cmd(FUNC_SET_HEAD, pick_amount(1), 0, 0);
      else if (r < 83) queue_cmd(FUNC_GOTO, 0, pick_coord(SCR_W), pick_coord(SCR_H));
      else if (r < 93) queue_cmd(FUNC_TELEPORT, 0, pick_coord(SCR_W), pick_coord(SCR_H));
      else queue_cmd(r[0] ? FUNC_SPARE_LO : FUNC_SPARE_HI, sx24(COORD_W'($urandom())),
                     sx24(COORD_W'($urandom())), sx24(COORD_W'($urandom())));
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_PEN_DOWN:  draw_en = val[0];
         CSR_PEN_COLOR: ink = val;
         CSR_WRAP:      wrap_on = val[0];
         default: ;
      endcase
   endtask

   task automatic set_pen(bit pd, logic [COLOR_W-1:0] col, bit wr);
      write_csr(CSR_PEN_DOWN, CSR_DATA_W'(pd));
      write_csr(CSR_PEN_COLOR, col);
      write_csr(CSR_WRAP, CSR_DATA_W'(wr));
   endtask

   // Hold until the queue is drained and every segment is back, then let the core settle.
   task automatic drain();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || segs_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 0;
         end else if (pending_cmds.size() != 0 &&
                      (calm || $urandom_range(0, 9) != 0)) begin
            req_item_type c;
            c = pending_cmds.pop_front();
            req_tvalid <= 1;
            req_tuser <= c.func;
            req_tdata <= {c.yt, c.xt, c.amount};
         end else begin
            req_tvalid <= 0;
            if (!calm && pending_cmds.size() != 0) send_gap <= $urandom_range(0, 10);
         end
      end
   end

   // Response backpressure.
   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1;
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_tready <= 0;
      end else if ($urandom_range(0, 14) == 0) begin
         recv_stall <= $urandom_range(0, 10);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   // Monitor: predict on accepted commands, check accepted segments.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) begin
         req_item_type c;
         c.func = req_tuser; c.amount = req_tdata[23:0];
         c.xt = req_tdata[47:24]; c.yt = req_tdata[71:48];
         predict_cmd(c);
         cmds_sent <= cmds_sent + 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         seg_type e;
         segs_seen <= segs_seen + 1;
         if (segs_due.size() == 0) begin
            $error("unexpected segment %h", rsp_tdata);
            fails = fails + 1;
         end else begin
            e = segs_due.pop_front();
            if (rsp_tdata[15:0] !== e.sx) begin
               $error("start_x exp %0d got %0d", signed'(e.sx), signed'(rsp_tdata[15:0]));
               fails = fails + 1;
            end
            if (rsp_tdata[31:16] !== e.sy) begin
               $error("start_y exp %0d got %0d", signed'(e.sy), signed'(rsp_tdata[31:16]));
               fails = fails + 1;
            end
            if (rsp_tdata[47:32] !== e.ex) begin
               $error("end_x exp %0d got %0d", signed'(e.ex), signed'(rsp_tdata[47:32]));
               fails = fails + 1;
            end
            if (rsp_tdata[63:48] !== e.ey) begin
               $error("end_y exp %0d got %0d", signed'(e.ey), signed'(rsp_tdata[63:48]));
               fails = fails + 1;
            end
            if (rsp_tdata[71:64] !== e.color) begin
               $error("line_color exp %0d got %0d", e.color, rsp_tdata[71:64]);
               fails = fails + 1;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_segment exp %0d got %0d", e.last, rsp_tlast);
               fails = fails + 1;
            end
         end
      end
   end

   initial begin
      pen_x = 0; pen_y = 0; head_q8 = 0;
      draw_en = 0; wrap_on = 0; ink = '0;
      for (int i = 0; i < FULL_TURN; i++) begin
         int q;
         q = i % 180;
         sine_deg[i] = QUARTER_SINE[q <= 90 ? q : 180 - q];
         if (i >= 180) sine_deg[i] = -sine_deg[i];
      end
      repeat (5) @(posedge clock);
      reset <= 0;

      // Directed: field extremes, every command, saturation, heading folds.
      set_pen(1, 8'd0, 0);
      queue_cmd(FUNC_GOTO, 0, Q_MIN, Q_MAX);
      queue_cmd(FUNC_FORWARD, Q_MAX, 0, 0);
      queue_cmd(FUNC_SET_HEAD, 90 * 256, 0, 0);
      queue_cmd(FUNC_FORWARD, Q_MIN, 0, 0);
      queue_cmd(FUNC_SET_HEAD, TURN_Q8, 0, 0);
      queue_cmd(FUNC_FORWARD, 10 * 256, 0, 0);
      queue_cmd(FUNC_RIGHT, 45 * 256 + 128, 0, 0);
      queue_cmd(FUNC_FORWARD, 300, 0, 0);
      queue_cmd(FUNC_LEFT, Q_MIN, 0, 0);
      queue_cmd(FUNC_FORWARD, -700, 0, 0);
      queue_cmd(FUNC_SET_HEAD, -1, 0, 0);
      queue_cmd(FUNC_FORWARD, 5000, 0, 0);
      queue_cmd(FUNC_TELEPORT, 0, 100 * 256, 50 * 256);
      queue_cmd(FUNC_SPARE_LO, Q_MAX, Q_MAX, Q_MAX);
      queue_cmd(FUNC_SPARE_HI, Q_MIN, Q_MIN, Q_MIN);
      queue_cmd(FUNC_GOTO, 0, -1, -256);
      drain();
      set_pen(1, 8'd255, 1);
      queue_cmd(FUNC_GOTO, 0, -5 * 256, 250 * 256);
      queue_cmd(FUNC_GOTO, 0, 330 * 256, -3 * 256);
      queue_cmd(FUNC_GOTO, 0, 20 * 256, 20 * 256);
      queue_cmd(FUNC_SET_HEAD, 270 * 256, 0, 0);
      queue_cmd(FUNC_FORWARD, 40 * 256, 0, 0);
      queue_cmd(FUNC_GOTO, 0, Q_MAX, Q_MIN);
      queue_cmd(FUNC_TELEPORT, 0, Q_MIN, Q_MAX);
      drain();

      // Random phases under changing pen settings; the last one runs without idling.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_pen(0, 8'd170, 1);
            1: set_pen(0, 8'd85, 0);
            2: set_pen(1, 8'd255, 0);
            3: set_pen(1, 8'd0, 1);
            default: set_pen($urandom_range(0, 3) != 0, CSR_DATA_W'($urandom()),
                             $urandom_range(0, 1) != 0);
         endcase
         if (ph == 7) calm = 1;
         for (int n = 0; n < 200; n++) queue_random();
         drain();
      end

      $display("commands accepted: %0d, segments checked: %0d", cmds_sent, segs_seen);
      $display("covered all commands, pen and wrap settings, saturation and heading folds");
      if (fails == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== turtle_vector_command_engine.f =====
+incdir+hdl
hdl/tvce_pkg.sv
hdl/tvce_front.sv
hdl/tvce_queue.sv
hdl/tvce_mod_unit.sv
hdl/tvce_back.sv
hdl/turtle_vector_command_engine.sv
hdl/tvce_checker.sv
dv/tb.sv
